// ===== src/vtms_pkg.sv =====
// Shared types and constants for the mosaic sheet sequencer.
// No dependencies.
package vtms_pkg;

	localparam int MAX_TILES = 30;
	localparam int SLOT_W    = 6;
	localparam int FPS_W     = 5;
	localparam int GAP_W     = 11;
	localparam int SIZE_W    = 13;
	localparam int PITCH_W   = SIZE_W + 1;
	localparam int PROD_W    = PITCH_W + SLOT_W;
	localparam int SUM_W     = PROD_W + 1;
	localparam int CFG_DW    = 13;
	localparam int HANDLE_W  = 8;

	typedef enum logic [2:0] {
		CMD_CLEAR      = 3'd0,
		CMD_COPY_PREV  = 3'd1,
		CMD_COPY_FRAME = 3'd2,
		CMD_BLANK      = 3'd3,
		CMD_EMIT       = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		CFG_GRID_COLUMNS = 3'd0,
		CFG_FRAMES       = 3'd1,
		CFG_OVERLAP      = 3'd2,
		CFG_PAD          = 3'd3,
		CFG_MARGIN       = 3'd4,
		CFG_GAP          = 3'd5,
		CFG_TILE_W       = 3'd6,
		CFG_TILE_H       = 3'd7
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_PAD,
		S_COPY_CHK,
		S_COPY_SRC,
		S_COPY_DST,
		S_FRAME,
		S_BLANK_CHK,
		S_BLANK,
		S_EMIT,
		S_POS
	} state_t;

endpackage

// ===== src/video_tile_mosaic_sequencer.sv =====
// Mosaic sheet sequencer: turns frame and end-of-stream events into rectangle commands.
// Each tile position is computed in the shared divide/multiply unit (6 divide steps,
// 2 multiplies, 2 margin adds); a plain frame copy is pushed once its position is ready.
// Items are handled one at a time: a new frame or end-of-stream event is taken only in idle.
// Reset: registers to defaults, no sheet open, no previous sheet, start padding pending.
module video_tile_mosaic_sequencer #(
	parameter int COORD_BITS = 18
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            kind,
	input  logic [vtms_pkg::HANDLE_W-1:0]   frame_handle,
	output logic                            out_valid,
	input  logic                            out_ready,
	output vtms_pkg::cmd_t                  command,
	output logic [COORD_BITS-1:0]           dest_x,
	output logic [COORD_BITS-1:0]           dest_y,
	output logic [COORD_BITS-1:0]           source_x,
	output logic [COORD_BITS-1:0]           source_y,
	output logic [vtms_pkg::HANDLE_W-1:0]   source_handle,
	output logic                            retain_sheet,
	output logic                            last,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  vtms_pkg::cfg_idx_t              cfg_index,
	input  logic [vtms_pkg::CFG_DW-1:0]     cfg_data
);
	import vtms_pkg::*;

	// configuration
	logic [FPS_W-1:0]  cols_q, fps_q, ovl_q, ipt_q;
	logic [GAP_W-1:0]  margin_q, gap_q;
	logic [SIZE_W-1:0] tw_q, th_q;

	// sequencer state
	state_t              state_q, state_d, ret_q, ret_d;
	logic [SLOT_W-1:0]   slot_q, slot_d, copy_i_q, copy_i_d, f_q, f_d;
	logic [FPS_W-1:0]    ov_q, ov_d;
	logic                open_q, open_d, prev_q, prev_d, pad_q, pad_d;
	logic [HANDLE_W-1:0] handle_q;
	logic [COORD_BITS-1:0] src_x_q, src_y_q;

	// position unit
	logic                 pos_busy_q, pos_start;
	logic [3:0]           pos_cnt_q;
	logic [SLOT_W-1:0]    dq_q, pos_slot;
	logic [FPS_W-1:0]     rem_q;
	logic [PROD_W-1:0]    prod_q, prod;
	logic [COORD_BITS-1:0] pos_x_q, pos_y_q;

	// output register
	logic                  out_valid_q, push, out_free;
	cmd_t                  o_cmd, cmd_q;
	logic [COORD_BITS-1:0] o_dx, o_dy, o_sx, o_sy, dx_q, dy_q, sx_q, sy_q;
	logic [HANDLE_W-1:0]   o_h, h_q;
	logic                  o_keep, o_last, keep_q, last_q;

	logic [SLOT_W-1:0]  f_eff, ov_eff, fps6, ovl6, slot_inc, copy_base;
	logic [FPS_W-1:0]   cols_eff;
	logic [SLOT_W-1:0]  div_tmp;
	logic               div_ge;
	logic [PITCH_W-1:0] pitch_x, pitch_y, mul_a;
	logic [SLOT_W-1:0]  mul_b;
	logic [SUM_W-1:0]   pos_sum;
	logic               clear_need;

	assign fps6     = {1'b0, fps_q};
	assign ovl6     = {1'b0, ovl_q};
	assign f_eff    = (fps_q == '0) ? SLOT_W'(1) :
	                  ((fps6 > SLOT_W'(MAX_TILES)) ? SLOT_W'(MAX_TILES) : fps6);
	assign ov_eff   = (ovl6 >= f_eff) ? (f_eff - SLOT_W'(1)) : ovl6;
	assign cols_eff = (cols_q == '0) ? FPS_W'(1) : cols_q;
	assign slot_inc = slot_q + SLOT_W'(1);
	assign copy_base = f_q - {1'b0, ov_q};
	assign clear_need = (margin_q != '0) || (gap_q != '0) || (pad_q && (ipt_q != '0));
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	// shared divide / multiply datapath
	assign div_tmp = {rem_q, dq_q[SLOT_W-1]};
	assign div_ge  = (div_tmp >= {1'b0, cols_eff});
	assign pitch_x = {1'b0, tw_q} + PITCH_W'(gap_q);
	assign pitch_y = {1'b0, th_q} + PITCH_W'(gap_q);
	assign mul_a   = (pos_cnt_q == 4'd6) ? pitch_x : pitch_y;
	assign mul_b   = (pos_cnt_q == 4'd6) ? {1'b0, rem_q} : dq_q;
	assign prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
	assign pos_sum = SUM_W'(margin_q) + SUM_W'(prod_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_busy_q <= 1'b0;
			pos_cnt_q  <= '0;
		end else if (pos_start) begin
			pos_busy_q <= 1'b1;
			pos_cnt_q  <= '0;
		end else if (pos_busy_q) begin
			pos_cnt_q <= pos_cnt_q + 4'd1;
			if (pos_cnt_q == 4'd8)
				pos_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pos_start) begin
			dq_q  <= pos_slot;
			rem_q <= '0;
		end else if (pos_busy_q) begin
			if (pos_cnt_q < 4'd6) begin
				rem_q <= div_ge ? FPS_W'(div_tmp - {1'b0, cols_eff}) : FPS_W'(div_tmp);
				dq_q  <= {dq_q[SLOT_W-2:0], div_ge};
			end
			if (pos_cnt_q == 4'd6 || pos_cnt_q == 4'd7)
				prod_q <= prod;
			if (pos_cnt_q == 4'd7)
				pos_x_q <= COORD_BITS'(pos_sum);
			if (pos_cnt_q == 4'd8)
				pos_y_q <= COORD_BITS'(pos_sum);
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q   <= FPS_W'(6);
			fps_q    <= FPS_W'(30);
			ovl_q    <= '0;
			ipt_q    <= '0;
			margin_q <= '0;
			gap_q    <= '0;
			tw_q     <= SIZE_W'(64);
			th_q     <= SIZE_W'(64);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_GRID_COLUMNS: cols_q   <= cfg_data[FPS_W-1:0];
				CFG_FRAMES:       fps_q    <= cfg_data[FPS_W-1:0];
				CFG_OVERLAP:      ovl_q    <= cfg_data[FPS_W-1:0];
				CFG_PAD:          ipt_q    <= cfg_data[FPS_W-1:0];
				CFG_MARGIN:       margin_q <= cfg_data[GAP_W-1:0];
				CFG_GAP:          gap_q    <= cfg_data[GAP_W-1:0];
				CFG_TILE_W:       tw_q     <= cfg_data[SIZE_W-1:0];
				CFG_TILE_H:       th_q     <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_comb begin
		state_d   = state_q;
		ret_d     = ret_q;
		slot_d    = slot_q;
		copy_i_d  = copy_i_q;
		f_d       = f_q;
		ov_d      = ov_q;
		open_d    = open_q;
		prev_d    = prev_q;
		pad_d     = pad_q;
		pos_start = 1'b0;
		pos_slot  = slot_q;
		push      = 1'b0;
		o_cmd     = CMD_CLEAR;
		o_dx      = '0;
		o_dy      = '0;
		o_sx      = '0;
		o_sy      = '0;
		o_h       = '0;
		o_keep    = 1'b0;
		o_last    = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					f_d  = f_eff;
					ov_d = FPS_W'(ov_eff);
					if (!kind) begin
						if (!open_q) begin
							state_d = S_CLEAR;
						end else begin
							pos_start = 1'b1;
							ret_d     = S_FRAME;
							state_d   = S_POS;
						end
					end else if (slot_q != '0 && open_q) begin
						state_d = S_BLANK_CHK;
					end
				end
			end
			S_CLEAR: begin
				open_d = 1'b1;
				if (!clear_need) begin
					state_d = S_PAD;
				end else if (out_free) begin
					push    = 1'b1;
					state_d = S_PAD;
				end
			end
			S_PAD: begin
				if (pad_q) begin
					if ({1'b0, ipt_q} < f_q)
						slot_d = {1'b0, ipt_q};
					pad_d = 1'b0;
				end
				copy_i_d = copy_base;
				state_d  = S_COPY_CHK;
			end
			S_COPY_CHK: begin
				pos_start = 1'b1;
				state_d   = S_POS;
				if (prev_q && copy_i_q < f_q) begin
					pos_slot = copy_i_q;
					ret_d    = S_COPY_SRC;
				end else begin
					ret_d = S_FRAME;
				end
			end
			S_COPY_SRC: begin
				pos_start = 1'b1;
				pos_slot  = copy_i_q - copy_base;
				ret_d     = S_COPY_DST;
				state_d   = S_POS;
			end
			S_COPY_DST: begin
				if (out_free) begin
					push     = 1'b1;
					o_cmd    = CMD_COPY_PREV;
					o_dx     = pos_x_q;
					o_dy     = pos_y_q;
					o_sx     = src_x_q;
					o_sy     = src_y_q;
					copy_i_d = copy_i_q + SLOT_W'(1);
					state_d  = S_COPY_CHK;
				end
			end
			S_FRAME: begin
				if (out_free) begin
					push    = 1'b1;
					o_cmd   = CMD_COPY_FRAME;
					o_dx    = pos_x_q;
					o_dy    = pos_y_q;
					o_h     = handle_q;
					o_last  = (slot_inc < f_q);
					slot_d  = slot_inc;
					state_d = (slot_inc < f_q) ? S_IDLE : S_BLANK_CHK;
				end
			end
			S_BLANK_CHK: begin
				if (slot_q < f_q) begin
					pos_start = 1'b1;
					ret_d     = S_BLANK;
					state_d   = S_POS;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_BLANK: begin
				if (out_free) begin
					push    = 1'b1;
					o_cmd   = CMD_BLANK;
					o_dx    = pos_x_q;
					o_dy    = pos_y_q;
					slot_d  = slot_inc;
					state_d = S_BLANK_CHK;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					push    = 1'b1;
					o_cmd   = CMD_EMIT;
					o_keep  = (ov_q != '0);
					o_last  = 1'b1;
					slot_d  = {1'b0, ov_q};
					if (ov_q != '0)
						prev_d = 1'b1;
					open_d  = 1'b0;
					state_d = S_IDLE;
				end
			end
			S_POS: begin
				if (!pos_busy_q)
					state_d = ret_q;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			slot_q      <= '0;
			copy_i_q    <= '0;
			f_q         <= '0;
			ov_q        <= '0;
			open_q      <= 1'b0;
			prev_q      <= 1'b0;
			pad_q       <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			ret_q    <= ret_d;
			slot_q   <= slot_d;
			copy_i_q <= copy_i_d;
			f_q      <= f_d;
			ov_q     <= ov_d;
			open_q   <= open_d;
			prev_q   <= prev_d;
			pad_q    <= pad_d;
			if (push)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			handle_q <= frame_handle;
		if (state_q == S_COPY_SRC) begin
			src_x_q <= pos_x_q;
			src_y_q <= pos_y_q;
		end
		if (push) begin
			cmd_q  <= o_cmd;
			dx_q   <= o_dx;
			dy_q   <= o_dy;
			sx_q   <= o_sx;
			sy_q   <= o_sy;
			h_q    <= o_h;
			keep_q <= o_keep;
			last_q <= o_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign command       = cmd_q;
	assign dest_x        = dx_q;
	assign dest_y        = dy_q;
	assign source_x      = sx_q;
	assign source_y      = sy_q;
	assign source_handle = h_q;
	assign retain_sheet  = keep_q;
	assign last          = last_q;

endmodule
